[rtl/euclidean_rhythm_generator_defines.svh]
// ---------------------------------------------------------------------------
// euclidean rhythm generator assertion macros
// ---------------------------------------------------------------------------
`ifndef EUCLIDEAN_RHYTHM_GENERATOR_DEFINES_SVH
`define EUCLIDEAN_RHYTHM_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ERG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ERG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/erg_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// erg_pkg
// shared constants, state type and controller/datapath command and status
// ---------------------------------------------------------------------------
package erg_pkg;

    localparam int MAX_STEPS = 32;
    localparam int OUT_W     = 32;
    localparam int PAT_W     = MAX_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);
    localparam int HITS_W    = 6;
    localparam int STEPS_W   = 6;
    localparam int ROT_W     = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_GROUP,
        ST_BUILD,
        ST_FINISH
    } erg_state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic group_step;
        logic build_step;
        logic finish;
    } erg_cmd_t;

    typedef struct packed {
        logic special;
        logic mod_done;
        logic group_done;
        logic build_done;
    } erg_sts_t;

endpackage

[rtl/erg_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// erg request and response channels
// valid/ready handshake carrying the rhythm parameters and the pattern
// ---------------------------------------------------------------------------
interface erg_req_if
    import erg_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [HITS_W-1:0]   hits;
    logic [STEPS_W-1:0]  steps;
    logic [ROT_W-1:0]    rotation;

    modport source (output valid, output hits, output steps, output rotation, input ready);
    modport sink   (input valid, input hits, input steps, input rotation, output ready);
endinterface

interface erg_rsp_if
    import erg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  rhythm_bits;

    modport source (output valid, output rhythm_bits, input ready);
    modport sink   (input valid, input rhythm_bits, output ready);
endinterface

[rtl/erg_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// erg_ctrl
// sequencer for remainder, grouping rounds, pattern build and result hand-off
// ---------------------------------------------------------------------------
module erg_ctrl
    import erg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  erg_sts_t  sts,
    output erg_cmd_t  cmd
);

    erg_state_t state_reg;
    erg_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                priority if (sts.special)
                    state_next = ST_FINISH;
                else if (sts.mod_done)
                    state_next = ST_GROUP;
            end
            ST_GROUP:
            begin
                if (sts.group_done)
                    state_next = ST_BUILD;
            end
            ST_BUILD:
            begin
                if (sts.build_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_MOD:
                cmd.mod_step = !sts.special && !sts.mod_done;
            ST_GROUP:
                cmd.group_step = !sts.group_done;
            ST_BUILD:
                cmd.build_step = !sts.build_done;
            ST_FINISH:
            begin
                cmd.finish = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

[rtl/erg_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// erg_datapath
// two-group bjorklund reduction, pattern build, rotation and result register
// ---------------------------------------------------------------------------
module erg_datapath
    import erg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  erg_cmd_t            cmd,
    output erg_sts_t            sts,
    input  logic [HITS_W-1:0]   hits,
    input  logic [STEPS_W-1:0]  steps,
    input  logic [ROT_W-1:0]    rotation,
    output logic [OUT_W-1:0]    rhythm_bits
);

    // every leading group is the same pattern a, every remainder group is b
    logic [CNT_W-1:0] n_reg, n_next;
    logic [ROT_W-1:0] rot_reg, rot_next;
    logic [PAT_W-1:0] a_reg, a_next, b_reg, b_next, pat_reg, pat_next;
    logic [CNT_W-1:0] a_len_reg, a_len_next, b_len_reg, b_len_next;
    logic [CNT_W-1:0] left_reg, left_next, right_reg, right_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             zero_reg, zero_next, full_reg, full_next;
    logic [OUT_W-1:0] out_reg, out_next;

    logic [CNT_W-1:0] n_clamp, h_clamp;
    logic [PAT_W-1:0] n_mask, rotated;
    logic [CNT_W-1:0] rot_ext;

    always_comb
    begin
        n_clamp = (steps > STEPS_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : CNT_W'(steps);
        h_clamp = (CNT_W'(hits) > n_clamp) ? n_clamp : CNT_W'(hits);
    end

    always_comb
    begin
        for (int i = 0; i < PAT_W; i++)
            n_mask[i] = (i < int'(n_reg));
    end

    assign rot_ext = CNT_W'(rot_reg);

    always_comb
    begin
        if (rot_reg == '0)
            rotated = pat_reg;
        else
            rotated = ((pat_reg >> rot_reg) | (pat_reg << (n_reg - rot_ext))) & n_mask;
    end

    assign sts.special    = zero_reg || full_reg;
    assign sts.mod_done   = rot_ext < n_reg;
    assign sts.group_done = right_reg <= CNT_W'(1);
    assign sts.build_done = (left_reg == '0) && (right_reg == '0);

    always_comb
    begin
        n_next     = n_reg;
        rot_next   = rot_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        a_len_next = a_len_reg;
        b_len_next = b_len_reg;
        left_next  = left_reg;
        right_next = right_reg;
        pat_next   = pat_reg;
        pos_next   = pos_reg;
        zero_next  = zero_reg;
        full_next  = full_reg;
        out_next   = out_reg;
        priority if (cmd.load)
        begin
            n_next     = n_clamp;
            rot_next   = rotation;
            a_next     = PAT_W'(1);
            b_next     = '0;
            a_len_next = CNT_W'(1);
            b_len_next = CNT_W'(1);
            left_next  = h_clamp;
            right_next = n_clamp - h_clamp;
            pat_next   = '0;
            pos_next   = '0;
            zero_next  = (n_clamp == '0) || (h_clamp == '0);
            full_next  = (h_clamp == n_clamp);
        end
        else if (cmd.mod_step)
        begin
            rot_next = rot_reg - n_reg[ROT_W-1:0];
        end
        else if (cmd.group_step)
        begin
            // append one remainder group to each leading group
            a_next     = a_reg | (b_reg << a_len_reg);
            a_len_next = a_len_reg + b_len_reg;
            if (left_reg <= right_reg)
            begin
                right_next = right_reg - left_reg;
            end
            else
            begin
                b_next     = a_reg;
                b_len_next = a_len_reg;
                left_next  = right_reg;
                right_next = left_reg - right_reg;
            end
        end
        else if (cmd.build_step)
        begin
            if (left_reg != '0)
            begin
                pat_next  = pat_reg | (a_reg << pos_reg);
                pos_next  = pos_reg + a_len_reg;
                left_next = left_reg - CNT_W'(1);
            end
            else
            begin
                pat_next   = pat_reg | (b_reg << pos_reg);
                pos_next   = pos_reg + b_len_reg;
                right_next = right_reg - CNT_W'(1);
            end
        end
        else if (cmd.finish)
        begin
            priority if (zero_reg)
                out_next = '0;
            else if (full_reg)
                out_next = OUT_W'(n_mask);
            else
                out_next = OUT_W'(rotated);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            zero_reg  <= 1'b1;
            full_reg  <= 1'b0;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            zero_reg  <= zero_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        rot_reg   <= rot_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        a_len_reg <= a_len_next;
        b_len_reg <= b_len_next;
        pat_reg   <= pat_next;
        pos_reg   <= pos_next;
        out_reg   <= out_next;
    end

    assign rhythm_bits = out_reg;

endmodule

[rtl/euclidean_rhythm_generator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euclidean_rhythm_generator
// bjorklund euclidean rhythm with rotation, one pattern per request
// ---------------------------------------------------------------------------
// usage
// req carries hits, steps and rotation; rsp returns rhythm_bits, bit i set
// when step i is a hit, bits at and above the step count zero
// a request is taken only while the block is idle; one response per request
// from the accepting edge to rsp.valid the block runs the remainder check
// and the subtractions reducing the rotation below the step count (up to
// 15), the round check and the grouping rounds of the shared shift-and-or
// unit, the layout check and the groups added one at a time while the
// pattern is laid out (up to 32 groups), then the rotate into the output
// register; grouping rounds and laid-out groups together never exceed the
// step count
// zero hits, zero steps or hits at or above steps skip straight to the output
// the result sits in an output register, so the next request is accepted
// while rsp is stalled; a stall only holds the block once it has a second
// result ready to hand over
// reset clears the sequencer and drops rsp.valid; no clearing pass is needed
// ---------------------------------------------------------------------------
`include "euclidean_rhythm_generator_defines.svh"

module euclidean_rhythm_generator
    import erg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    erg_req_if.sink    req,
    erg_rsp_if.source  rsp
);

    erg_cmd_t cmd;
    erg_sts_t sts;

    erg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    erg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .hits        (req.hits),
        .steps       (req.steps),
        .rotation    (req.rotation),
        .rhythm_bits (rsp.rhythm_bits)
    );

    // a taken request keeps the block busy until its result enters the output register
    `ERG_ASSERT_NEXT(a_busy_after_load, cmd.load, !req.ready, "ready high right after a request")
    `ERG_ASSERT_NEXT(a_valid_after_finish, cmd.finish, rsp.valid, "result lost at hand-off")
    `ERG_ASSERT_NOW(a_one_cmd, 1'b1,
        $onehot0({cmd.load, cmd.mod_step, cmd.group_step, cmd.build_step, cmd.finish}),
        "more than one datapath command")

endmodule
